>>> src/crxf_pkg.sv
// Shared types, constants and the identifier lookup for the CAN receive filter block.
package crxf_pkg;

  localparam int unsigned IdW       = 29;
  localparam int unsigned LenW      = 4;
  localparam int unsigned DataW     = 64;
  localparam int unsigned CntW      = 32;
  localparam int unsigned LevelOutW = 8;
  localparam int unsigned NumIds    = 14;
  localparam int unsigned IdxW      = 4;

  // Request codes; the fourth code is unused and does nothing
  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WB   = 1'b1
  } state_e;

  // Accepted identifiers, in counter index order
  localparam logic [IdW-1:0] ID_TABLE [NumIds] = '{
    29'h1A7, 29'h2A7, 29'h3A7, 29'h4A7,
    29'h200, 29'h201, 29'h202, 29'h203, 29'h204,
    29'h210, 29'h400, 29'h401, 29'h402, 29'h500
  };

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
  } id_hit_t;

  // Counter memory access, from controller to counter store
  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_idx;
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
    logic [CntW-1:0] wr_data;
  } cnt_req_t;

  // One FIFO entry: header (length code, identifier) and data bytes
  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [IdW-1:0]   ident;
    logic [DataW-1:0] data;
  } frame_t;

  // One result item
  typedef struct packed {
    logic                 frame_matched;
    logic                 frame_dropped;
    logic                 pop_valid;
    logic [IdW-1:0]       out_identifier;
    logic [LenW-1:0]      out_length;
    logic [DataW-1:0]     out_payload;
    logic [CntW-1:0]      id_count;
    logic [CntW-1:0]      total_count;
    logic [LevelOutW-1:0] fifo_level;
  } res_t;

  // Full 29-bit compare against every table entry; entries are distinct
  function automatic id_hit_t id_lookup(input logic [IdW-1:0] ident);
    id_hit_t r;
    r = '0;
    for (int i = 0; i < NumIds; i++) begin
      if (ident == ID_TABLE[i]) begin
        r.hit = 1'b1;
        r.idx = IdxW'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> src/crxf_if.sv
// Valid/ready channel interfaces for request and result items.
interface crxf_in_if import crxf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [IdW-1:0]   identifier;
  logic [LenW-1:0]  length;
  logic [DataW-1:0] payload;

  modport source (output valid, output operation, output identifier, output length,
                  output payload, input ready);
  modport sink   (input valid, input operation, input identifier, input length,
                  input payload, output ready);
endinterface

interface crxf_out_if import crxf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 frame_matched;
  logic                 frame_dropped;
  logic                 pop_valid;
  logic [IdW-1:0]       out_identifier;
  logic [LenW-1:0]      out_length;
  logic [DataW-1:0]     out_payload;
  logic [CntW-1:0]      id_count;
  logic [CntW-1:0]      total_count;
  logic [LevelOutW-1:0] fifo_level;

  modport source (output valid, output frame_matched, output frame_dropped,
                  output pop_valid, output out_identifier, output out_length,
                  output out_payload, output id_count, output total_count,
                  output fifo_level, input ready);
  modport sink   (input valid, input frame_matched, input frame_dropped,
                  input pop_valid, input out_identifier, input out_length,
                  input out_payload, input id_count, input total_count,
                  input fifo_level, output ready);
endinterface

>>> src/can_rx_id_filter_counter_fifo_unit.sv
// CAN receive acceptance filter: per-identifier counters and a receive FIFO behind it.
// One request item is handled at a time: at acceptance the
// counter memory and the FIFO memory are read (counter of the matched identifier,
// frame at the FIFO head), and in the following cycle the counter and FIFO are
// written back and the result item is loaded into the output register. The next
// request is accepted in the cycle after that load, so no new request is taken
// before the result of the last one is loaded; a stalled result holds the
// block in its write-back cycle. No clearing pass is needed after reset.
module can_rx_id_filter_counter_fifo_unit import crxf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  crxf_in_if.sink      in_i,
  crxf_out_if.source   out_o
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned LvlW = $clog2(FIFO_DEPTH + 1);

  state_e state_q, state_d;

  // Request captured at acceptance
  logic [1:0]       op_q;
  logic [IdW-1:0]   ident_q;
  logic [LenW-1:0]  len_q;
  logic [DataW-1:0] data_q;
  id_hit_t          hit_q;
  id_hit_t          hit_in;

  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [LvlW-1:0] level_q, level_d;
  logic [CntW-1:0] total_q, total_d;

  logic     accept;
  logic     commit;
  cnt_req_t cnt_req;
  logic [CntW-1:0] cnt_rd;

  frame_t fifo_mem [FIFO_DEPTH];
  frame_t fifo_rd_q;
  frame_t fifo_wr;
  logic   fifo_we;

  res_t res_d, res_q;
  logic out_valid_q;

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    return (p == PtrW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign hit_in    = id_lookup(in_i.identifier);
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept    = in_i.valid && in_i.ready;
  assign commit    = (state_q == ST_WB) && (!out_valid_q || out_o.ready);

  // Capture request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_i.operation;
      ident_q <= in_i.identifier;
      len_q   <= in_i.length;
      data_q  <= in_i.payload;
      hit_q   <= hit_in;
    end
  end

  // FIFO memory: head read at acceptance, push at write-back
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fifo_rd_q <= fifo_mem[rd_ptr_q];
    end
    if (fifo_we) begin
      fifo_mem[wr_ptr_q] <= fifo_wr;
    end
  end

  crxf_cnt_mem u_cnt_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (cnt_req),
    .rd_data_o (cnt_rd)
  );

  // Next state, write-back and result
  always_comb begin
    state_d  = state_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    level_d  = level_q;
    total_d  = total_q;
    fifo_we  = 1'b0;
    fifo_wr  = '{len: len_q, ident: ident_q, data: data_q};
    res_d    = '0;

    cnt_req         = '0;
    cnt_req.rd_en   = accept && hit_in.hit;
    cnt_req.rd_idx  = hit_in.idx;
    cnt_req.wr_idx  = hit_q.idx;
    cnt_req.wr_data = cnt_rd + 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        case (op_e'(op_q))
          OP_RX: begin
            if (hit_q.hit) begin
              res_d.frame_matched = 1'b1;
              cnt_req.wr_en       = commit;
              total_d             = total_q + 1'b1;
              if (level_q == LvlW'(FIFO_DEPTH)) begin
                res_d.frame_dropped = 1'b1;
              end else begin
                fifo_we  = commit;
                wr_ptr_d = advance(wr_ptr_q);
                level_d  = level_q + 1'b1;
              end
            end
          end
          OP_POP: begin
            if (level_q != '0) begin
              res_d.pop_valid      = 1'b1;
              res_d.out_identifier = fifo_rd_q.ident;
              res_d.out_length     = fifo_rd_q.len;
              res_d.out_payload    = fifo_rd_q.data;
              rd_ptr_d             = advance(rd_ptr_q);
              level_d              = level_q - 1'b1;
            end
          end
          OP_QUERY: begin
            if (hit_q.hit) begin
              res_d.id_count = cnt_rd;
            end
          end
          default: begin
          end
        endcase
        res_d.total_count = total_d;
        res_d.fifo_level  = LevelOutW'(level_d);
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers; pointers, level and total update only when the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      level_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        rd_ptr_q    <= rd_ptr_d;
        wr_ptr_q    <= wr_ptr_d;
        level_q     <= level_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.frame_matched  = res_q.frame_matched;
  assign out_o.frame_dropped  = res_q.frame_dropped;
  assign out_o.pop_valid      = res_q.pop_valid;
  assign out_o.out_identifier = res_q.out_identifier;
  assign out_o.out_length     = res_q.out_length;
  assign out_o.out_payload    = res_q.out_payload;
  assign out_o.id_count       = res_q.id_count;
  assign out_o.total_count    = res_q.total_count;
  assign out_o.fifo_level     = res_q.fifo_level;

endmodule

>>> src/crxf_cnt_mem.sv
// Per-identifier counter store: synchronous memory with per-entry valid bits.
module crxf_cnt_mem import crxf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cnt_req_t        req_i,
  output logic [CntW-1:0] rd_data_o
);

  logic [CntW-1:0] mem [NumIds];
  logic [NumIds-1:0] vld_q, vld_d;
  logic [CntW-1:0] rd_data_q;
  logic            rd_vld_q;

  // Counter array, registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_idx] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_idx];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_comb begin
    vld_d = vld_q;
    if (req_i.wr_en) begin
      vld_d[req_i.wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_idx];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the CAN receive filter with counters and receive FIFO.
module tb_top;
  import crxf_pkg::*;

  localparam int unsigned Depth      = 128;
  localparam int unsigned TargetOps  = 1350;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 10;
  localparam logic [1:0]  OpUnused   = 2'd3;

  // Stimulus mix per phase
  localparam int unsigned ModeFill  = 0;
  localparam int unsigned ModeDrain = 1;
  localparam int unsigned ModeMixed = 2;

  // Tracks filter, counters and FIFO contents; holds the results still due
  class can_filter_scoreboard;
    frame_t          frame_store [Depth];
    int unsigned     rd_ptr, wr_ptr, level;
    logic [CntW-1:0] per_id [NumIds];
    logic [CntW-1:0] total;
    res_t            awaited [$];
    int unsigned     errors, requests, results_seen, drops, empty_pops, peak_level;

    function new();
      rd_ptr = 0;
      wr_ptr = 0;
      level = 0;
      total = '0;
      foreach (per_id[i]) per_id[i] = '0;
      errors = 0;
      requests = 0;
      results_seen = 0;
      drops = 0;
      empty_pops = 0;
      peak_level = 0;
    endfunction

    // Table position of an identifier, -1 when it is not accepted
    function int table_slot(logic [IdW-1:0] ident);
      for (int i = 0; i < NumIds; i++) begin
        if (ID_TABLE[i] == ident) return i;
      end
      return -1;
    endfunction

    function void note_request(logic [1:0] op, logic [IdW-1:0] ident,
                               logic [LenW-1:0] len, logic [DataW-1:0] data);
      res_t want;
      int   slot;
      want = '0;
      slot = table_slot(ident);
      requests++;
      case (op)
        OP_RX: begin
          if (slot >= 0) begin
            want.frame_matched = 1'b1;
            per_id[slot] = per_id[slot] + 1;
            total = total + 1;
            // counters move even when the frame is dropped
            if (level >= Depth) begin
              want.frame_dropped = 1'b1;
              drops++;
            end else begin
              frame_store[wr_ptr] = '{len: len, ident: ident, data: data};
              wr_ptr = (wr_ptr + 1) % Depth;
              level++;
              if (level > peak_level) peak_level = level;
            end
          end
        end
        OP_POP: begin
          if (level != 0) begin
            want.pop_valid      = 1'b1;
            want.out_identifier = frame_store[rd_ptr].ident;
            want.out_length     = frame_store[rd_ptr].len;
            want.out_payload    = frame_store[rd_ptr].data;
            rd_ptr = (rd_ptr + 1) % Depth;
            level--;
          end else begin
            empty_pops++;
          end
        end
        OP_QUERY: begin
          if (slot >= 0) want.id_count = per_id[slot];
        end
        default: ;
      endcase
      want.total_count = total;
      want.fifo_level  = LevelOutW'(level);
      awaited.push_back(want);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [DataW-1:0] got, logic [DataW-1:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                         results_seen, name, got, want));
      end
    endtask

    task check_result(res_t got);
      res_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", results_seen));
        return;
      end
      want = awaited.pop_front();
      compare_field("frame_matched", got.frame_matched, want.frame_matched);
      compare_field("frame_dropped", got.frame_dropped, want.frame_dropped);
      compare_field("pop_valid", got.pop_valid, want.pop_valid);
      compare_field("out_identifier", got.out_identifier, want.out_identifier);
      compare_field("out_length", got.out_length, want.out_length);
      compare_field("out_payload", got.out_payload, want.out_payload);
      compare_field("id_count", got.id_count, want.id_count);
      compare_field("total_count", got.total_count, want.total_count);
      compare_field("fifo_level", got.fifo_level, want.fifo_level);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  crxf_in_if  in_bus ();
  crxf_out_if out_bus ();

  can_filter_scoreboard sb = new();

  int unsigned idle_pct  = 25;
  int unsigned stall_pct = 25;
  int unsigned cycles    = 0;

  can_rx_id_filter_counter_fifo_unit #(
    .FIFO_DEPTH(Depth)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, sb.awaited.size());
      $display("can_rx_id_filter_counter_fifo_unit test failed");
      $finish;
    end
  end

  // Result side back-pressure
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_bus.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
    end
  end

  // Handshake monitor: check results first, then record the accepted request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        sb.check_result(res_t'({out_bus.frame_matched, out_bus.frame_dropped,
                                out_bus.pop_valid, out_bus.out_identifier,
                                out_bus.out_length, out_bus.out_payload,
                                out_bus.id_count, out_bus.total_count,
                                out_bus.fifo_level}));
      end
      if (in_bus.valid && in_bus.ready) begin
        sb.note_request(in_bus.operation, in_bus.identifier, in_bus.length,
                        in_bus.payload);
      end
    end
  end

  // Present one request item and hold it until accepted
  task automatic send_request(input logic [1:0] op, input logic [IdW-1:0] ident,
                              input logic [LenW-1:0] len, input logic [DataW-1:0] data);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= op;
    in_bus.identifier <= ident;
    in_bus.length     <= len;
    in_bus.payload    <= data;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  // One random request; useful is set for items the block acts on
  task automatic send_random(input int unsigned mode, output bit useful);
    int unsigned     cut [3][4];
    int unsigned     roll;
    logic [1:0]      op;
    logic [IdW-1:0]  known_id, odd_id;
    logic [DataW-1:0] data;
    cut[ModeFill]  = '{88, 92, 97, 99};
    cut[ModeDrain] = '{10, 15, 23, 98};
    cut[ModeMixed] = '{35, 45, 65, 95};
    roll     = $urandom_range(99);
    known_id = ID_TABLE[$urandom_range(NumIds - 1)];
    // unknown identifiers: one-bit near misses (some land on another entry) or anything at all
    odd_id   = $urandom_range(1) ? (known_id ^ (IdW'(1) << $urandom_range(IdW - 1)))
                                 : IdW'($urandom());
    data     = {$urandom(), $urandom()};
    useful   = 1'b1;
    if (roll < cut[mode][0]) begin
      send_request(OP_RX, known_id, LenW'($urandom_range(15)), data);
    end else if (roll < cut[mode][1]) begin
      useful = 1'b0;
      send_request(OP_RX, odd_id, LenW'($urandom_range(15)), data);
    end else if (roll < cut[mode][2]) begin
      send_request(OP_QUERY, ($urandom_range(99) < 80) ? known_id : odd_id,
                   LenW'($urandom_range(15)), data);
    end else if (roll < cut[mode][3]) begin
      send_request(OP_POP, IdW'($urandom()), LenW'($urandom_range(15)), data);
    end else begin
      useful = 1'b0;
      send_request(OpUnused, IdW'($urandom()), LenW'($urandom_range(15)), data);
    end
  endtask

  initial begin
    int unsigned useful_count;
    int unsigned phase;
    int unsigned mode;
    int unsigned span;
    bit          useful;

    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.operation  = OP_RX;
    in_bus.identifier = '0;
    in_bus.length     = '0;
    in_bus.payload    = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pop, unknown queries, the unused code, every table entry
    send_request(OP_POP, '0, '0, '0);
    send_request(OP_QUERY, '0, '0, '0);
    send_request(OP_QUERY, 29'h1A7 | (IdW'(1) << 28), '0, '0);
    send_request(OpUnused, '1, '1, '1);
    for (int i = 0; i < NumIds; i++) begin
      send_request(OP_RX, ID_TABLE[i], (i % 2) ? '1 : '0, (i % 2) ? '1 : '0);
    end
    // unmatched frames: all-ones identifier and a neighbor of a table entry
    send_request(OP_RX, '1, '1, '1);
    send_request(OP_RX, 29'h1A6, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_request(OP_QUERY, 29'h500, '0, '0);
    send_request(OP_QUERY, 29'h1A7, '1, '1);
    send_request(OP_POP, '1, '1, '1);
    send_request(OP_POP, '0, '0, '0);

    // Random phases: fill past full, drain past empty, then mixed traffic
    useful_count = 0;
    phase = 0;
    while (sb.requests < TargetOps) begin
      mode = phase % 3;
      // one long stretch with no idling on either side
      idle_pct  = (phase == 3) ? 0 : 25;
      stall_pct = (phase == 3) ? 0 : 25;
      span = (mode == ModeMixed) ? $urandom_range(40, 120) : $urandom_range(180, 240);
      repeat (span) begin
        send_random(mode, useful);
        useful_count += useful;
      end
      phase++;
    end
    in_bus.valid <= 1'b0;
    @(posedge clk_i);

    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Covered %0d requests (%0d random ones acted on) and %0d results;",
             sb.requests, useful_count, sb.results_seen);
    $display("%0d frames dropped on a full FIFO, %0d pops on an empty FIFO, peak level %0d.",
             sb.drops, sb.empty_pops, sb.peak_level);
    if (sb.errors == 0) begin
      $display("can_rx_id_filter_counter_fifo_unit test passed");
    end else begin
      $display("can_rx_id_filter_counter_fifo_unit test failed");
    end
    $finish;
  end

endmodule
